// ----- sv/edtp_pkg.sv -----
// Shared types and constants for the earliest-deadline task picker.
// No dependencies; the controller, datapath, top and testbench import this package.
package edtp_pkg;

	// Operation codes carried on the request channel
	typedef enum logic [1:0] {
		OP_INIT   = 2'd0,
		OP_PICK   = 2'd1,
		OP_FINISH = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// A task is eligible only below this next-run time
	localparam logic [31:0] ELIGIBLE_LIMIT = 32'h7FFF_FFFF;
	// Microseconds per millisecond, at the 33-bit sum width
	localparam logic [32:0] US_PER_MS_33 = 33'd1000;
	// x / 1000 = (x >> 3) / 125; below 2^30 the divide by 125 is a multiply by
	// ceil(2^37 / 125) followed by a shift right by 37
	localparam logic [30:0] US_RECIP_125 = 31'd1099511628;

	// One table entry
	typedef struct packed {
		logic [31:0] run_at;
		logic [31:0] used_ms;
		logic [9:0]  used_us;
	} entry_t;

	// Controller to datapath commands
	typedef struct packed {
		logic req_ready;
		logic mem_rd;
		logic rd_scan;
		logic wr_init;
		logic wr_fin;
		logic el_load;
		logic fin_load;
		logic div_step;
		logic div_apply;
		logic scan_clear;
		logic scan_issue;
		logic scan_commit;
		logic out_load;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic req_taken;
		op_t  op;
		logic carry;
		logic scan_empty;
		logic scan_last;
		logic out_free;
	} dp_sts_t;

endpackage

// ----- sv/edtp_req_if.sv -----
// Request channel: one beat carries one operation for the task picker.
// Uses no package; fields are plain vectors.
interface edtp_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [3:0]  task_index;
	logic [31:0] time_value;
	logic [31:0] start_us;
	logic [31:0] end_us;
	logic [31:0] now_ms;

	modport source (
		output valid, operation, task_index, time_value, start_us, end_us, now_ms,
		input  ready
	);
	modport sink (
		input  valid, operation, task_index, time_value, start_us, end_us, now_ms,
		output ready
	);
endinterface

// ----- sv/edtp_res_if.sv -----
// Result channel: one beat carries the chosen task and its totals.
// Uses no package; fields are plain vectors.
interface edtp_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  chosen_task;
	logic [31:0] chosen_next_run;
	logic [31:0] wait_ms;
	logic [31:0] used_ms;
	logic [9:0]  used_us;
	logic        no_task;

	modport source (
		output valid, chosen_task, chosen_next_run, wait_ms, used_ms, used_us, no_task,
		input  ready
	);
	modport sink (
		input  valid, chosen_task, chosen_next_run, wait_ms, used_ms, used_us, no_task,
		output ready
	);
endinterface

// ----- sv/earliest_deadline_task_picker_top.sv -----
// Earliest-deadline task picker: task table with pick, init and finish operations.
// Init writes one entry; pick scans the first task_count entries, one table read a cycle;
// finish updates the current task, with a divide step when the microsecond total carries,
// then scans like pick. One operation at a time: the next beat can be taken from the
// cycle after the result loads.
// Reset (arst_n low, asynchronous) clears the table, current task and task count.
module earliest_deadline_task_picker_top #(
	parameter int MAX_TASKS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	edtp_req_if.sink   task_req,
	edtp_res_if.source task_res,
	input  logic       cfg_wr_en,
	input  logic [4:0] cfg_wr_data
);
	import edtp_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer
	edtp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Table and arithmetic
	edtp_dp #(
		.MAX_TASKS (MAX_TASKS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.task_req    (task_req),
		.task_res    (task_res),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

// ----- sv/edtp_ctrl.sv -----
// Controller state machine of the task picker.
// Depends on edtp_pkg for the command, status and operation types.
module edtp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  edtp_pkg::dp_sts_t sts,
	output edtp_pkg::dp_cmd_t cmd
);
	import edtp_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE       = 13'b0000000000001,
		S_DISPATCH   = 13'b0000000000010,
		S_INIT_WR    = 13'b0000000000100,
		S_FIN_RD     = 13'b0000000001000,
		S_FIN_CALC   = 13'b0000000010000,
		S_DIV        = 13'b0000000100000,
		S_DIV_END    = 13'b0000001000000,
		S_FIN_WR     = 13'b0000010000000,
		S_SCAN_START = 13'b0000100000000,
		S_SCAN       = 13'b0001000000000,
		S_SCAN_DONE  = 13'b0010000000000,
		S_COMMIT     = 13'b0100000000000,
		S_RES_OUT    = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   res_rd;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		res_rd  = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.req_ready = 1'b1;
				if (sts.req_taken) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (sts.op)
					OP_INIT:   state_d = S_INIT_WR;
					OP_PICK:   state_d = S_SCAN_START;
					OP_FINISH: state_d = S_FIN_RD;
					default: begin
						// unused code: just report the current task
						res_rd  = 1'b1;
						state_d = S_RES_OUT;
					end
				endcase
			end
			S_INIT_WR: begin
				cmd.wr_init = 1'b1;
				// init result reads the current task next
				state_d     = S_SCAN_DONE;
			end
			S_FIN_RD: begin
				cmd.mem_rd  = 1'b1;
				cmd.el_load = 1'b1;
				state_d     = S_FIN_CALC;
			end
			S_FIN_CALC: begin
				cmd.fin_load = 1'b1;
				state_d      = sts.carry ? S_DIV : S_FIN_WR;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				state_d      = S_DIV_END;
			end
			S_DIV_END: begin
				cmd.div_apply = 1'b1;
				state_d       = S_FIN_WR;
			end
			S_FIN_WR: begin
				cmd.wr_fin = 1'b1;
				state_d    = S_SCAN_START;
			end
			S_SCAN_START: begin
				cmd.scan_clear = 1'b1;
				state_d        = sts.scan_empty ? S_COMMIT : S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				cmd.mem_rd     = 1'b1;
				cmd.rd_scan    = 1'b1;
				if (sts.scan_last) state_d = S_SCAN_DONE;
			end
			S_SCAN_DONE: begin
				// last compare lands here; an init passes through to its readout
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.scan_commit = (sts.op != OP_INIT);
				res_rd          = 1'b1;
				state_d         = S_RES_OUT;
			end
			S_RES_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		// read of the current task entry for the result
		if (res_rd) cmd.mem_rd = 1'b1;
	end

endmodule

// ----- sv/edtp_dp.sv -----
// Datapath of the task picker: task table, finish update, divider and scan.
// Depends on edtp_pkg and on the request and result channel interfaces.
module edtp_dp #(
	parameter int MAX_TASKS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	edtp_req_if.sink          task_req,
	edtp_res_if.source        task_res,
	input  logic              cfg_wr_en,
	input  logic [4:0]        cfg_wr_data,
	input  edtp_pkg::dp_cmd_t cmd,
	output edtp_pkg::dp_sts_t sts
);
	import edtp_pkg::*;

	localparam int IW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CLW = $clog2(MAX_TASKS + 1);
	localparam int SW  = (CLW > 5) ? CLW : 5;

	// Latched request
	op_t         op_q;
	logic [3:0]  idx_q;
	logic [31:0] tv_q, su_q, eu_q, now_q;
	logic        accept;

	// Config, current task and flag
	logic [4:0]    tc_q;
	logic [IW-1:0] cur_q;
	logic          flag_q;

	// Task table
	entry_t                mem [MAX_TASKS];
	logic [MAX_TASKS-1:0]  valid_q;
	entry_t                rd_q;
	logic                  rd_vld_q;
	entry_t                rd_ent;
	logic [IW-1:0]         rd_addr, wr_addr;
	logic                  wr_en, in_range;
	entry_t                wr_data;

	// Finish update and millisecond carry
	logic [31:0] el_q, nr_q, ms_q;
	logic [9:0]  us_q;
	logic [32:0] div_q, sum;
	logic [22:0] quo_q;
	logic [59:0] recip_prod;
	logic [32:0] quo_rem;

	// Scan
	logic [SW-1:0] limit, scan_i_q;
	logic          scan_vld_s1;
	logic [IW-1:0] scan_idx_s1, best_q;
	logic [31:0]   best_time_q;
	logic          found_q;

	// Result register
	logic        out_vld_q;
	logic [3:0]  o_task_q;
	logic [31:0] o_nr_q, o_wait_q, o_ms_q;
	logic [9:0]  o_us_q;
	logic        o_flag_q;

	assign task_req.ready = cmd.req_ready;
	assign accept         = task_req.valid & cmd.req_ready;

	// Request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(task_req.operation);
			idx_q <= task_req.task_index;
			tv_q  <= task_req.time_value;
			su_q  <= task_req.start_us;
			eu_q  <= task_req.end_us;
			now_q <= task_req.now_ms;
		end
	end

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= '0;
		end else if (cfg_wr_en) begin
			tc_q <= cfg_wr_data;
		end
	end

	// Table ports: one write, one registered read
	// the result read after a pick follows the task being committed
	assign in_range = (32'(idx_q) < 32'(MAX_TASKS));
	assign wr_en    = (cmd.wr_init & in_range) | cmd.wr_fin;
	assign wr_addr  = cmd.wr_init ? IW'(idx_q) : cur_q;
	assign rd_addr  = cmd.rd_scan ? scan_i_q[IW-1:0] :
	                  (cmd.scan_commit & found_q) ? best_q : cur_q;
	always_comb begin
		if (cmd.wr_init) begin
			wr_data = '{run_at: tv_q, used_ms: 32'd0, used_us: 10'd0};
		end else begin
			wr_data = '{run_at: nr_q, used_ms: ms_q, used_us: us_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.mem_rd) rd_q <= mem[rd_addr];
	end

	// Entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) valid_q[wr_addr] <= 1'b1;
			if (cmd.mem_rd) rd_vld_q <= valid_q[rd_addr];
		end
	end
	assign rd_ent = rd_vld_q ? rd_q : '0;

	// Finish update: elapsed time, new totals, carry of (sum - 1) / 1000
	assign sum        = 33'(rd_ent.used_us) + 33'(el_q);
	// (sum - 1) >> 3 stays below 2^30, so the quotient is exact and under 2^23
	assign recip_prod = 60'(div_q[32:3]) * 60'(US_RECIP_125);
	assign quo_rem    = div_q - 33'(quo_q) * US_PER_MS_33;
	always_ff @(posedge clk) begin
		if (cmd.el_load) el_q <= (eu_q > su_q) ? (eu_q - su_q) : 32'd0;
		if (cmd.fin_load) begin
			nr_q  <= rd_ent.run_at + tv_q;
			ms_q  <= rd_ent.used_ms;
			us_q  <= sum[9:0];
			div_q <= sum - 33'd1;
		end else if (cmd.div_step) begin
			quo_q <= recip_prod[59:37];
		end else if (cmd.div_apply) begin
			// remainder is below 1000, so the leftover lands in 1..1000
			ms_q <= ms_q + 32'(quo_q);
			us_q <= quo_rem[9:0] + 10'd1;
		end
	end

	// Scan over the first task_count entries, lowest index wins ties
	assign limit = (SW'(tc_q) > SW'(MAX_TASKS)) ? SW'(MAX_TASKS) : SW'(tc_q);
	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_i_q[IW-1:0];
		if (cmd.scan_clear) begin
			scan_i_q    <= '0;
			best_time_q <= ELIGIBLE_LIMIT;
			best_q      <= '0;
			found_q     <= 1'b0;
		end else begin
			if (cmd.scan_issue) scan_i_q <= scan_i_q + SW'(1);
			if (scan_vld_s1 && (rd_ent.run_at < best_time_q)) begin
				best_time_q <= rd_ent.run_at;
				best_q      <= scan_idx_s1;
				found_q     <= 1'b1;
			end
		end
	end

	// Scan pipeline valid, current task and no-task flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_vld_s1 <= 1'b0;
			cur_q       <= '0;
			flag_q      <= 1'b0;
		end else begin
			scan_vld_s1 <= cmd.scan_issue;
			if (accept) begin
				flag_q <= 1'b0;
			end else if (cmd.scan_commit) begin
				flag_q <= ~found_q;
				if (found_q) cur_q <= best_q;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (task_res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_task_q <= 4'(cur_q);
			o_nr_q   <= rd_ent.run_at;
			o_wait_q <= (rd_ent.run_at > now_q) ? (rd_ent.run_at - now_q) : 32'd0;
			o_ms_q   <= rd_ent.used_ms;
			o_us_q   <= rd_ent.used_us;
			o_flag_q <= flag_q;
		end
	end

	assign task_res.valid           = out_vld_q;
	assign task_res.chosen_task     = o_task_q;
	assign task_res.chosen_next_run = o_nr_q;
	assign task_res.wait_ms         = o_wait_q;
	assign task_res.used_ms         = o_ms_q;
	assign task_res.used_us         = o_us_q;
	assign task_res.no_task         = o_flag_q;

	// Status to the controller
	assign sts.req_taken  = accept;
	assign sts.op         = op_q;
	assign sts.carry      = (sum > US_PER_MS_33);
	assign sts.scan_empty = (limit == '0);
	assign sts.scan_last  = (scan_i_q == (limit - SW'(1)));
	assign sts.out_free   = ~out_vld_q | task_res.ready;

endmodule

// ----- dv/tb_earliest_deadline_task_picker_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for earliest_deadline_task_picker_top: directed and random beats
// with a task-table predictor that follows each accepted beat. Depends on edtp_pkg and the two channel interfaces.
module tb_earliest_deadline_task_picker_top;
	import edtp_pkg::*;

	localparam int          MAX_TASKS    = 16;
	localparam int          HALF_PERIOD  = 10;
	localparam int          RESET_CYCLES = 6;
	localparam int          DRAIN_CYCLES = 80;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned RANDOM_BEATS = 220;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	// One request beat
	typedef struct {
		op_t         op;
		logic [3:0]  idx;
		logic [31:0] tv;
		logic [31:0] su;
		logic [31:0] eu;
		logic [31:0] now;
	} task_req_t;

	// One result beat
	typedef struct {
		logic [3:0]  chosen;
		logic [31:0] run_at;
		logic [31:0] wait_ms;
		logic [31:0] used_ms;
		logic [9:0]  used_us;
		logic        no_task;
	} pick_result_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [4:0] cfg_wr_data;

	edtp_req_if req_if ();
	edtp_res_if res_if ();

	earliest_deadline_task_picker_top #(
		.MAX_TASKS(MAX_TASKS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.task_req   (req_if),
		.task_res   (res_if),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Predictor copy of the task table
	logic [31:0] nr_tbl [MAX_TASKS];
	logic [31:0] ms_tbl [MAX_TASKS];
	logic [9:0]  us_tbl [MAX_TASKS];
	logic [3:0]  cur_task_m;
	logic [4:0]  task_cnt_m;

	task_req_t    task_requests [$];
	pick_result_t expected_picks [$];
	task_req_t    beat_in_flight;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned err_count;
	int unsigned beats_sent;
	int unsigned results_seen;
	int unsigned no_task_seen;
	int unsigned cycle_cnt;
	logic [31:0] time_base;

	int unsigned phase_tasks [8] = '{16, 3, 31, 1, 16, 0, 8, 17};

	always #(HALF_PERIOD) clk = ~clk;

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH at result %0d, %s: got 0x%h, expected 0x%h",
			results_seen, what, got, want);
		err_count++;
	endtask

	// Scan the first task_count entries for the earliest eligible next-run
	function automatic logic pick_earliest();
		int unsigned lim;
		logic [31:0] best_t;
		logic [3:0]  best;
		logic        found;
		lim = (task_cnt_m > MAX_TASKS) ? MAX_TASKS : task_cnt_m;
		best_t = ELIGIBLE_LIMIT;
		best = '0;
		found = 1'b0;
		for (int unsigned i = 0; i < lim; i++) begin
			if (nr_tbl[i] < best_t) begin
				best_t = nr_tbl[i];
				best = 4'(i);
				found = 1'b1;
			end
		end
		if (found)
			cur_task_m = best;
		return found;
	endfunction

	// Apply one accepted beat to the table and queue the result it causes
	task automatic predict_pick(task_req_t rq);
		pick_result_t res;
		logic [63:0]  sum;
		logic [63:0]  carry;
		logic         flag;
		logic [3:0]   t;
		flag = 1'b0;
		case (rq.op)
			OP_INIT: begin
				nr_tbl[rq.idx] = rq.tv;
				ms_tbl[rq.idx] = '0;
				us_tbl[rq.idx] = '0;
			end
			OP_PICK: begin
				flag = !pick_earliest();
			end
			OP_FINISH: begin
				t = cur_task_m;
				nr_tbl[t] = nr_tbl[t] + rq.tv;
				sum = 64'(us_tbl[t]);
				if (rq.eu > rq.su)
					sum = sum + 64'(rq.eu - rq.su);
				// carry whole milliseconds, leaving 1..1000 us unless the sum is zero
				if (sum > 64'd1000) begin
					carry = (sum - 64'd1) / 64'd1000;
					ms_tbl[t] = ms_tbl[t] + 32'(carry);
					sum = sum - carry * 64'd1000;
				end
				us_tbl[t] = 10'(sum);
				flag = !pick_earliest();
			end
			default: ;
		endcase
		t = cur_task_m;
		res.chosen   = t;
		res.run_at   = nr_tbl[t];
		res.wait_ms  = (nr_tbl[t] > rq.now) ? nr_tbl[t] - rq.now : '0;
		res.used_ms  = ms_tbl[t];
		res.used_us  = us_tbl[t];
		res.no_task  = flag;
		expected_picks.push_back(res);
	endtask

	// Driver: present queued beats, idling at random between them
	always @(posedge clk or negedge arst_n) begin : drv_proc
		task_req_t nxt;
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				predict_pick(beat_in_flight);
				beats_sent++;
			end
			if (!req_if.valid || req_if.ready) begin
				if (task_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = task_requests.pop_front();
					beat_in_flight = nxt;
					req_if.valid      <= 1'b1;
					req_if.operation  <= nxt.op;
					req_if.task_index <= nxt.idx;
					req_if.time_value <= nxt.tv;
					req_if.start_us   <= nxt.su;
					req_if.end_us     <= nxt.eu;
					req_if.now_ms     <= nxt.now;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random back-pressure, compare each result beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : mon_proc
		pick_result_t want;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (expected_picks.size() == 0) begin
					report_mismatch("result with nothing expected", 32'(res_if.chosen_task), '0);
				end else begin
					want = expected_picks.pop_front();
					if (res_if.chosen_task !== want.chosen)
						report_mismatch("chosen_task", 32'(res_if.chosen_task), 32'(want.chosen));
					if (res_if.chosen_next_run !== want.run_at)
						report_mismatch("chosen_next_run", res_if.chosen_next_run, want.run_at);
					if (res_if.wait_ms !== want.wait_ms)
						report_mismatch("wait_ms", res_if.wait_ms, want.wait_ms);
					if (res_if.used_ms !== want.used_ms)
						report_mismatch("used_ms", res_if.used_ms, want.used_ms);
					if (res_if.used_us !== want.used_us)
						report_mismatch("used_us", 32'(res_if.used_us), 32'(want.used_us));
					if (res_if.no_task !== want.no_task)
						report_mismatch("no_task", 32'(res_if.no_task), 32'(want.no_task));
					if (want.no_task)
						no_task_seen++;
				end
				results_seen++;
			end
			res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, expected_picks.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic add_request(op_t op, logic [3:0] idx, logic [31:0] tv,
			logic [31:0] su, logic [31:0] eu, logic [31:0] now);
		task_req_t rq;
		rq.op  = op;
		rq.idx = idx;
		rq.tv  = tv;
		rq.su  = su;
		rq.eu  = eu;
		rq.now = now;
		task_requests.push_back(rq);
	endtask

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			IDLE_SEND: begin send_idle_pct = 77; recv_stall_pct = 0;  end
			IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 77; end
			default:   begin send_idle_pct = 33; recv_stall_pct = 33; end
		endcase
	endtask

	// Wait until every beat is sent and answered, then let the block settle;
	// sampled at the falling edge so the driver's updates have landed
	task automatic wait_idle();
		while (task_requests.size() > 0 || req_if.valid || expected_picks.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_task_count(logic [4:0] cnt);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cnt;
		task_cnt_m = cnt;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Mostly near the running base, now and then any 32-bit value
	function automatic logic [31:0] rand_near(logic [31:0] base, int unsigned span);
		if ($urandom_range(99) < 85)
			return base + $urandom_range(span);
		return $urandom;
	endfunction

	// Random beats: inits mostly around the current time, finishes mostly with short run intervals
	task automatic queue_random_requests(int unsigned count);
		task_req_t   rq;
		int unsigned r;
		for (int unsigned k = 0; k < count; k++) begin
			r = $urandom_range(99);
			rq.op = (r < 25) ? OP_INIT : (r < 45) ? OP_PICK : (r < 95) ? OP_FINISH : OP_NONE;
			rq.idx = 4'($urandom_range(15));
			time_base = time_base + $urandom_range(30);
			rq.now = rand_near(time_base, 40);
			rq.tv  = $urandom;
			rq.su  = $urandom;
			rq.eu  = $urandom;
			if (rq.op == OP_INIT) begin
				r = $urandom_range(99);
				if (r < 75)
					rq.tv = time_base + $urandom_range(300);
				else if (r < 88)
					rq.tv = ELIGIBLE_LIMIT - 32'd1 + $urandom_range(2);
			end else if (rq.op == OP_FINISH) begin
				if ($urandom_range(99) < 85)
					rq.tv = $urandom_range(150, 1);
				r = $urandom_range(99);
				if (r < 80)
					rq.eu = rq.su + $urandom_range(2500);
				else if (r < 85)
					rq.eu = rq.su;
			end
			task_requests.push_back(rq);
		end
	endtask

	initial begin : stim_proc
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_if.valid = 1'b0;
		req_if.operation = OP_INIT;
		req_if.task_index = '0;
		req_if.time_value = '0;
		req_if.start_us = '0;
		req_if.end_us = '0;
		req_if.now_ms = '0;
		res_if.ready = 1'b0;
		err_count = 0;
		beats_sent = 0;
		results_seen = 0;
		no_task_seen = 0;
		cycle_cnt = 0;
		for (int i = 0; i < MAX_TASKS; i++) begin
			nr_tbl[i] = '0;
			ms_tbl[i] = '0;
			us_tbl[i] = '0;
		end
		cur_task_m = '0;
		task_cnt_m = '0;
		time_base = $urandom & 32'h3FFF_FFFF;
		set_idling(IDLE_NONE);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset count of zero: picks find nothing, finish still updates task 0
		add_request(OP_PICK, 4'd0, '0, '0, '0, '0);
		add_request(OP_FINISH, 4'd0, 32'd5, 32'd0, 32'd1500, 32'd0);
		add_request(OP_NONE, 4'hF, '1, '1, '1, '1);
		wait_idle();

		// Full table: ineligible edges, ties among zeros, wrap and carry corners
		write_task_count(5'd16);
		set_idling(IDLE_BOTH);
		add_request(OP_INIT, 4'd0, ELIGIBLE_LIMIT, '0, '0, '0);
		add_request(OP_INIT, 4'd1, ELIGIBLE_LIMIT - 32'd1, '0, '0, '0);
		add_request(OP_INIT, 4'd15, '1, '0, '0, '0);
		add_request(OP_PICK, 4'd0, '0, '0, '0, '1);
		add_request(OP_FINISH, 4'd0, '1, 32'd0, '1, 32'd0);
		add_request(OP_FINISH, 4'd0, ELIGIBLE_LIMIT, 32'd10, 32'd10, 32'd0);
		add_request(OP_FINISH, 4'd0, 32'd1, '1, 32'd0, 32'd0);
		add_request(OP_FINISH, 4'd0, 32'd1000, 32'd0, 32'd1000, 32'd0);
		add_request(OP_FINISH, 4'd0, 32'd2000, 32'd0, 32'd1001, 32'd999);
		add_request(OP_PICK, 4'd0, '0, '0, '0, '0);
		add_request(OP_INIT, 4'd5, '0, '1, '1, '1);
		add_request(OP_NONE, 4'd0, '0, '0, '0, '0);
		wait_idle();

		// Count above the table size scans every entry
		write_task_count(5'd31);
		set_idling(IDLE_SEND);
		add_request(OP_PICK, 4'd0, '0, '0, '0, 32'h8000_0000);
		add_request(OP_INIT, 4'd14, '0, '0, '0, '0);
		add_request(OP_FINISH, 4'd0, 32'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
		wait_idle();

		// Single scanned task: while it is not eligible the current task stays put, then an init makes it eligible
		write_task_count(5'd1);
		set_idling(IDLE_RECV);
		add_request(OP_PICK, 4'd0, '0, '0, '0, '0);
		add_request(OP_INIT, 4'd0, 32'd7, '0, '0, 32'd3);
		add_request(OP_PICK, 4'd0, '0, '0, '0, 32'd3);
		wait_idle();

		// Random phases across task counts and idling patterns
		for (int unsigned k = 0; k < 8; k++) begin
			write_task_count(5'(phase_tasks[k]));
			set_idling(idle_mode_t'(k % 4));
			queue_random_requests(RANDOM_BEATS);
			wait_idle();
		end

		if (expected_picks.size() != 0)
			report_mismatch("results never received", 32'(expected_picks.size()), '0);
		$display("Ran %0d request beats and checked %0d result beats, %0d with no eligible task",
			beats_sent, results_seen, no_task_seen);
		$display("Task counts 0 to 31 exercised with sender and receiver idling off and on");
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- earliest_deadline_task_picker_top.f -----
sv/edtp_pkg.sv
sv/edtp_req_if.sv
sv/edtp_res_if.sv
sv/edtp_ctrl.sv
sv/edtp_dp.sv
sv/earliest_deadline_task_picker_top.sv
dv/tb_earliest_deadline_task_picker_top.sv
